// ===== sv/ucpd_pkg.sv =====
// shared types, constants and helpers for the serial command dimmer
`default_nettype none

package ucpd_pkg;

    localparam int CMD_ON     = 0;
    localparam int CMD_OFF    = 1;
    localparam int CMD_STATUS = 2;
    localparam int CMD_PWM    = 3;
    localparam int NUM_CMDS   = 4;
    localparam int CMD_MAX    = 6;

    localparam logic [7:0] CMD_TEXT [NUM_CMDS][CMD_MAX] = '{
        '{8'h4F, 8'h4E, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4F, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00},
        '{8'h53, 8'h74, 8'h61, 8'h74, 8'h75, 8'h73},
        '{8'h50, 8'h57, 8'h4D, 8'h3A, 8'h00, 8'h00}
    };
    localparam logic [2:0] CMD_LEN [NUM_CMDS] = '{3'd2, 3'd3, 3'd6, 3'd4};

    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam logic [6:0]  DUTY_MAX    = 7'd100;
    localparam logic [6:0]  NUM_CAP     = 7'd127;
    localparam logic [15:0] COMPARE_MAX = 16'hFFFF;

    localparam logic [6:0] DEFAULT_DUTY_RESET = 7'd80;
    localparam logic [9:0] CPP_RESET          = 10'd10;

    localparam logic CFG_DEFAULT_DUTY = 1'b0;
    localparam logic CFG_COMPARE_PER  = 1'b1;

    typedef enum logic [2:0] {
        RESP_NONE   = 3'd0,
        RESP_ON     = 3'd1,
        RESP_OFF    = 3'd2,
        RESP_STATUS = 3'd3,
        RESP_DUTY   = 3'd4,
        RESP_ERROR  = 3'd5
    } resp_t;

    // decoded command for the line collected so far
    typedef struct packed {
        logic       on;
        logic       off;
        logic       status;
        logic       pwm;
        logic [6:0] pwm_duty;
    } cmd_t;

    function automatic logic [6:0] clamp_duty(input logic [6:0] duty);
        return (duty > DUTY_MAX) ? DUTY_MAX : duty;
    endfunction

    // duty times counts per percent, saturated to 16 bits
    function automatic logic [15:0] compare_for(input logic [6:0] duty,
                                                input logic [9:0] per_pct);
        logic [16:0] prod;
        prod = 17'(clamp_duty(duty)) * 17'(per_pct);
        return (prod > 17'(COMPARE_MAX)) ? COMPARE_MAX : prod[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/ucpd_line.sv =====
// command line collector: keyword matching and number accumulation per byte
`default_nettype none

module ucpd_line #(
    parameter int MAX_TEXT_LEN = 31
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic [7:0]    rx_char,
    output ucpd_pkg::cmd_t     cmd
);

    localparam int LEN_W = $clog2(MAX_TEXT_LEN + 1);

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_SIGN,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    logic [LEN_W-1:0] len_reg, len_next;
    logic [3:0]       flags_reg, flags_next;
    phase_t           phase_reg, phase_next;
    logic [6:0]       value_reg, value_next;
    logic             neg_reg, neg_next;

    logic             printable;
    logic             digit;
    logic [10:0]      acc;

    assign printable = rx_char inside {[8'd32:8'd127]};
    assign digit     = rx_char inside {[8'h30:8'h39]};
    assign acc       = 11'(value_reg) * 11'd10 + 11'(rx_char[3:0]);

    always_comb
    begin
        len_next   = len_reg;
        flags_next = flags_reg;
        phase_next = phase_reg;
        value_next = value_reg;
        neg_next   = neg_reg;
        if (step && (rx_char == ucpd_pkg::CHAR_BANG ||
                     (printable && len_reg == LEN_W'(MAX_TEXT_LEN))))
        begin
            // end of line, or overflow restarts the line empty
            len_next   = '0;
            flags_next = '1;
            phase_next = PH_LEAD;
            value_next = '0;
            neg_next   = 1'b0;
        end
        else if (step && printable)
        begin
            for (int i = 0; i < ucpd_pkg::NUM_CMDS; i++)
            begin
                if (len_reg < LEN_W'(ucpd_pkg::CMD_LEN[i]))
                begin
                    if (rx_char != ucpd_pkg::CMD_TEXT[i][len_reg[2:0]])
                        flags_next[i] = 1'b0;
                end
                else if (i != ucpd_pkg::CMD_PWM)
                begin
                    flags_next[i] = 1'b0;
                end
            end
            if (len_reg >= LEN_W'(ucpd_pkg::CMD_LEN[ucpd_pkg::CMD_PWM]))
            begin
                case (phase_reg)
                    PH_LEAD:
                    begin
                        if (rx_char == ucpd_pkg::CHAR_SPACE)
                        begin
                            phase_next = PH_LEAD;
                        end
                        else if (rx_char == ucpd_pkg::CHAR_PLUS ||
                                 rx_char == ucpd_pkg::CHAR_MINUS)
                        begin
                            neg_next   = (rx_char == ucpd_pkg::CHAR_MINUS);
                            phase_next = PH_SIGN;
                        end
                        else if (digit)
                        begin
                            value_next = 7'(rx_char[3:0]);
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_SIGN, PH_DIGITS:
                    begin
                        if (digit)
                        begin
                            // saturate while accumulating
                            value_next = (acc > 11'(ucpd_pkg::NUM_CAP)) ?
                                         ucpd_pkg::NUM_CAP : acc[6:0];
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase
            end
            len_next = len_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            flags_reg <= '1;
            phase_reg <= PH_LEAD;
            value_reg <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            flags_reg <= flags_next;
            phase_reg <= phase_next;
            value_reg <= value_next;
            neg_reg   <= neg_next;
        end
    end

    assign cmd.on     = flags_reg[ucpd_pkg::CMD_ON] &&
                        len_reg == LEN_W'(ucpd_pkg::CMD_LEN[ucpd_pkg::CMD_ON]);
    assign cmd.off    = flags_reg[ucpd_pkg::CMD_OFF] &&
                        len_reg == LEN_W'(ucpd_pkg::CMD_LEN[ucpd_pkg::CMD_OFF]);
    assign cmd.status = flags_reg[ucpd_pkg::CMD_STATUS] &&
                        len_reg == LEN_W'(ucpd_pkg::CMD_LEN[ucpd_pkg::CMD_STATUS]);
    assign cmd.pwm    = flags_reg[ucpd_pkg::CMD_PWM] &&
                        len_reg >= LEN_W'(ucpd_pkg::CMD_LEN[ucpd_pkg::CMD_PWM]);
    assign cmd.pwm_duty = neg_reg ? 7'd0 : ucpd_pkg::clamp_duty(value_reg);

endmodule

`default_nettype wire

// ===== sv/uart_command_pwm_dimmer.sv =====
// serial command dimmer top level: input register, command execution, result register
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------------------
//   in      | in        | in_valid / in_ready   | rx_byte
//   out     | out       | out_valid / out_ready | echo_byte, response, lamp_on,
//           |           |                      | duty_percent, pwm_compare
//   cfg     | in        | cfg_write            | cfg_index, cfg_data
//
// one byte per cycle while the result is not stalled; a beat goes from the input register to the result register
// the whole per-byte update (match, accumulate, 7x10 multiply and saturate) is one register stage
// reset clears the line, lamp off, duty and compare zero, registers to their defaults
// a stalled result holds the pipe; the input register still takes a beat while it is empty
`default_nettype none

module uart_command_pwm_dimmer #(
    parameter int MAX_TEXT_LEN = 31
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       echo_byte,
    output logic [2:0]       response,
    output logic             lamp_on,
    output logic [6:0]       duty_percent,
    output logic [15:0]      pwm_compare,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [9:0]  cfg_data
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    logic [7:0]  echo_reg;
    ucpd_pkg::resp_t resp_reg, resp_next;
    logic        lamp_reg, lamp_next;
    logic [6:0]  duty_reg, duty_next;
    logic [15:0] compare_reg, compare_next;
    logic [6:0]  default_duty_reg;
    logic [9:0]  cpp_reg;
    logic        advance;
    logic [6:0]  on_duty;
    ucpd_pkg::cmd_t cmd;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    ucpd_line #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN)
    ) u_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_char (in_byte_reg),
        .cmd     (cmd)
    );

    assign on_duty = (duty_reg == 7'd0) ? ucpd_pkg::clamp_duty(default_duty_reg) : duty_reg;

    always_comb
    begin
        resp_next    = ucpd_pkg::RESP_NONE;
        lamp_next    = lamp_reg;
        duty_next    = duty_reg;
        compare_next = compare_reg;
        if (in_byte_reg == ucpd_pkg::CHAR_BANG)
        begin
            if (cmd.on)
            begin
                lamp_next    = 1'b1;
                duty_next    = on_duty;
                compare_next = ucpd_pkg::compare_for(on_duty, cpp_reg);
                resp_next    = ucpd_pkg::RESP_ON;
            end
            else if (cmd.off)
            begin
                lamp_next    = 1'b0;
                compare_next = '0;
                resp_next    = ucpd_pkg::RESP_OFF;
            end
            else if (cmd.status)
            begin
                resp_next = ucpd_pkg::RESP_STATUS;
            end
            else if (cmd.pwm)
            begin
                duty_next = cmd.pwm_duty;
                if (lamp_reg)
                    compare_next = ucpd_pkg::compare_for(cmd.pwm_duty, cpp_reg);
                resp_next = ucpd_pkg::RESP_DUTY;
            end
            else
            begin
                resp_next = ucpd_pkg::RESP_ERROR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lamp_reg      <= 1'b0;
            duty_reg      <= '0;
            compare_reg   <= '0;
            resp_reg      <= ucpd_pkg::RESP_NONE;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                resp_reg      <= resp_next;
                lamp_reg      <= lamp_next;
                duty_reg      <= duty_next;
                compare_reg   <= compare_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_byte_reg <= rx_byte;
        if (advance)
            echo_reg <= in_byte_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_duty_reg <= ucpd_pkg::DEFAULT_DUTY_RESET;
            cpp_reg          <= ucpd_pkg::CPP_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ucpd_pkg::CFG_DEFAULT_DUTY: default_duty_reg <= cfg_data[6:0];
                ucpd_pkg::CFG_COMPARE_PER:  cpp_reg          <= cfg_data;
                default:                    cpp_reg          <= cpp_reg;
            endcase
        end
    end

    // lamp state and duty belong to the beat in the result register
    assign out_valid    = out_valid_reg;
    assign echo_byte    = echo_reg;
    assign response     = resp_reg;
    assign lamp_on      = lamp_reg;
    assign duty_percent = duty_reg;
    assign pwm_compare  = compare_reg;

    a_resp_only_on_bang: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && resp_reg != ucpd_pkg::RESP_NONE |-> echo_reg == ucpd_pkg::CHAR_BANG)
        else $error("response on a byte other than the line end");

    a_off_means_no_compare: assert property (@(posedge clk) disable iff (!rst_n)
        !lamp_reg |-> compare_reg == 16'd0)
        else $error("compare nonzero with lamp off");

    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        duty_reg <= ucpd_pkg::DUTY_MAX)
        else $error("stored duty above limit");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled with room in the pipe");

endmodule

`default_nettype wire
